// ----- sv/dcsf_pkg.sv -----
// shared types, widths and helpers for the distance constraint spring force block
`default_nettype none
package dcsf_pkg;

	localparam int FIELD_W   = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int Q_FRAC    = 16;

	localparam int D_W      = FIELD_W + 1;      // coordinate difference
	localparam int SUM_W    = 2 * D_W;          // sum of three squares
	localparam int LEN_W    = D_W;              // floor square root
	localparam int DIR_W    = Q_FRAC + 2;       // unit direction, |dir| <= 1.0
	localparam int DISP_W   = LEN_W + 2;
	localparam int DOT_W    = D_W + DIR_W + 1;
	localparam int TOT_W    = 48;               // force terms, clamped to 2^46-1
	localparam int MUL_W    = 48;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int FSUM_W   = 2 * (TOT_W - 1);
	localparam int MUL_DIGIT = 4;

	localparam logic [LEN_W-1:0] TOO_CLOSE_RAW = LEN_W'(7);
	localparam logic [TOT_W-2:0] MID_LIMIT =
		(TOT_W-1)'((64'd1 << (TOT_W - 2)) - 64'd1);

	localparam logic [1:0] LAST_LANE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BREAKABLE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BREAK_F   = 3'd5;

	typedef enum logic [2:0] {
		OUT_WITHIN    = 3'd0,
		OUT_APPLIED   = 3'd1,
		OUT_TOO_CLOSE = 3'd2,
		OUT_BROKE     = 3'd3,
		OUT_BROKEN    = 3'd4
	} outcome_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_SQ, OP_ROOT, OP_DIV, OP_DOT,
		OP_SPRING, OP_DAMP, OP_FORCE, OP_FSQ, OP_BRK
	} op_t;

	typedef struct packed {
		logic       load;
		logic       start;
		op_t        op;
		logic [1:0] lane;
		logic       plain;
		logic       show;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic too_close;
		logic in_range;
		logic spring_mode;
		logic breakable;
		logic brk;
	} stat_t;

	// (a*b)>>16 magnitude clamped to the force term limit
	function automatic logic [TOT_W-2:0] sat_mid(input logic [PROD_W-Q_FRAC-1:0] v);
		if (v > (PROD_W-Q_FRAC)'(MID_LIMIT))
			return MID_LIMIT;
		return v[TOT_W-2:0];
	endfunction

endpackage
`default_nettype wire

// ----- sv/dcsf_in_if.sv -----
// request channel carrying two bodies' positions and velocities
`default_nettype none
interface dcsf_in_if;
	import dcsf_pkg::*;
	logic valid;
	logic ready;
	logic signed [FIELD_W-1:0] pos_a_x, pos_a_y, pos_a_z;
	logic signed [FIELD_W-1:0] pos_b_x, pos_b_y, pos_b_z;
	logic signed [FIELD_W-1:0] vel_a_x, vel_a_y, vel_a_z;
	logic signed [FIELD_W-1:0] vel_b_x, vel_b_y, vel_b_z;

	modport source (output valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
		vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z, input ready);
	modport sink (input valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
		vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z, output ready);
endinterface
`default_nettype wire

// ----- sv/dcsf_out_if.sv -----
// result channel carrying the force on body b and the outcome code
`default_nettype none
interface dcsf_out_if;
	import dcsf_pkg::*;
	logic valid;
	logic ready;
	logic signed [FIELD_W-1:0] force_x, force_y, force_z;
	logic [2:0] outcome;

	modport source (output valid, force_x, force_y, force_z, outcome, input ready);
	modport sink (input valid, force_x, force_y, force_z, outcome, output ready);
endinterface
`default_nettype wire

// ----- sv/distance_constraint_spring_force.sv -----
// Distance constraint with spring/damper force and break latch. One request at a time: the
// block forms the separation of body b from body a, its floor length and unit direction, and
// answers with the force on body b (signed Q16.16, saturated) and an outcome code. An already
// broken constraint answers soonest and the full spring, damper and break path takes longest.
// The time is set by the shared multiplier, which retires one 4-bit digit of its second operand
// per cycle and stops after the last nonzero digit, by the 33-step square root and by three
// 17-step divides for the direction. The result is held until taken; the next request is
// accepted the cycle after. Configuration writes are taken at any time and must only be made
// while no request is in flight.
`default_nettype none
module distance_constraint_spring_force (
	input  logic                              clk,
	input  logic                              arst_n,
	dcsf_in_if.sink                           in_ch,
	dcsf_out_if.source                        out_ch,
	input  logic                              cfg_we,
	input  logic [dcsf_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [dcsf_pkg::CFG_W-1:0]        cfg_wdata
);
	import dcsf_pkg::*;

	cmd_t     cmd;
	stat_t    stat;
	outcome_t outcome;
	logic signed [FIELD_W-1:0] pos_a [3];
	logic signed [FIELD_W-1:0] pos_b [3];
	logic signed [FIELD_W-1:0] vel_a [3];
	logic signed [FIELD_W-1:0] vel_b [3];
	logic signed [FIELD_W-1:0] force_o [3];

	assign pos_a[0] = in_ch.pos_a_x;
	assign pos_a[1] = in_ch.pos_a_y;
	assign pos_a[2] = in_ch.pos_a_z;
	assign pos_b[0] = in_ch.pos_b_x;
	assign pos_b[1] = in_ch.pos_b_y;
	assign pos_b[2] = in_ch.pos_b_z;
	assign vel_a[0] = in_ch.vel_a_x;
	assign vel_a[1] = in_ch.vel_a_y;
	assign vel_a[2] = in_ch.vel_a_z;
	assign vel_b[0] = in_ch.vel_b_x;
	assign vel_b[1] = in_ch.vel_b_y;
	assign vel_b[2] = in_ch.vel_b_z;

	assign out_ch.force_x = force_o[0];
	assign out_ch.force_y = force_o[1];
	assign out_ch.force_z = force_o[2];
	assign out_ch.outcome = outcome;

	dcsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.outcome   (outcome),
		.cmd       (cmd),
		.stat      (stat)
	);

	dcsf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.pos_a     (pos_a),
		.pos_b     (pos_b),
		.vel_a     (vel_a),
		.vel_b     (vel_b),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.force_o   (force_o)
	);
endmodule
`default_nettype wire

// ----- sv/dcsf_mul.sv -----
// shared unsigned multiplier, one 4-bit digit of b per cycle, stops at the last nonzero digit
`default_nettype none
module dcsf_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [dcsf_pkg::MUL_W-1:0]   a,
	input  logic [dcsf_pkg::MUL_W-1:0]   b,
	output logic                         done,
	output logic [dcsf_pkg::PROD_W-1:0]  prod
);
	import dcsf_pkg::*;

	logic               busy_q;
	logic [PROD_W-1:0]  a_q;
	logic [PROD_W-1:0]  acc_q;
	logic [MUL_W-1:0]   b_q;

	assign done = busy_q && (b_q == '0);
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= PROD_W'(a);
			b_q   <= b;
		end else if (busy_q && (b_q != '0)) begin
			acc_q <= acc_q + a_q * b_q[MUL_DIGIT-1:0];
			a_q   <= a_q << MUL_DIGIT;
			b_q   <= b_q >> MUL_DIGIT;
		end
	end
endmodule
`default_nettype wire

// ----- sv/dcsf_root.sv -----
// floor square root, two radicand bits per cycle
`default_nettype none
module dcsf_root (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [dcsf_pkg::SUM_W-1:0]   radicand,
	output logic                         done,
	output logic [dcsf_pkg::LEN_W-1:0]   root
);
	import dcsf_pkg::*;

	localparam int RW  = LEN_W + 4;
	localparam int CW  = $clog2(LEN_W + 1);

	logic               busy_q, done_q;
	logic [CW-1:0]      cnt_q;
	logic [SUM_W-1:0]   rad_q;
	logic [RW-1:0]      rem_q;
	logic [LEN_W-1:0]   root_q;
	logic [RW-1:0]      rem_sh, trial;
	logic               ge;

	assign rem_sh = {rem_q[RW-3:0], rad_q[SUM_W-1 -: 2]};
	assign trial  = RW'({root_q, 2'b01});
	assign ge     = rem_sh >= trial;
	assign done   = done_q;
	assign root   = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(LEN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[LEN_W-2:0], ge};
		end
	end
endmodule
`default_nettype wire

// ----- sv/dcsf_div.sv -----
// restoring divider for (|d| << 16) / len, one quotient bit per cycle
`default_nettype none
module dcsf_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [dcsf_pkg::D_W-1:0]     num,
	input  logic [dcsf_pkg::LEN_W-1:0]   den,
	output logic                         done,
	output logic [dcsf_pkg::DIR_W-2:0]   quo
);
	import dcsf_pkg::*;

	localparam int QW = DIR_W - 1;
	localparam int CW = $clog2(QW + 1);

	logic               busy_q, done_q;
	logic [CW-1:0]      cnt_q;
	logic [LEN_W:0]     rem_q;
	logic [QW-1:0]      sh_q, q_q;
	logic [LEN_W-1:0]   den_q;
	logic [LEN_W:0]     rem_sh;
	logic               ge;

	// quotient never exceeds 1.0, so the top dividend bits start in the remainder
	assign rem_sh = {rem_q[LEN_W-1:0], sh_q[QW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign done   = done_q;
	assign quo    = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= (LEN_W+1)'(num >> 1);
			sh_q  <= {num[0], {(QW-1){1'b0}}};
			q_q   <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			sh_q  <= sh_q << 1;
			q_q   <= {q_q[QW-2:0], ge};
		end
	end
endmodule
`default_nettype wire

// ----- sv/dcsf_dp.sv -----
// datapath: configuration registers, operand registers and the shared arithmetic units
`default_nettype none
module dcsf_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dcsf_pkg::cmd_t                    cmd,
	output dcsf_pkg::stat_t                   stat,
	input  logic signed [dcsf_pkg::FIELD_W-1:0] pos_a [3],
	input  logic signed [dcsf_pkg::FIELD_W-1:0] pos_b [3],
	input  logic signed [dcsf_pkg::FIELD_W-1:0] vel_a [3],
	input  logic signed [dcsf_pkg::FIELD_W-1:0] vel_b [3],
	input  logic                              cfg_we,
	input  logic [dcsf_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [dcsf_pkg::CFG_W-1:0]        cfg_wdata,
	output logic signed [dcsf_pkg::FIELD_W-1:0] force_o [3]
);
	import dcsf_pkg::*;

	localparam logic signed [TOT_W:0] MID_POS = signed'((TOT_W+1)'(MID_LIMIT));
	localparam logic signed [TOT_W:0] MID_NEG = -MID_POS;
	localparam logic signed [TOT_W-1:0] O_MAX = TOT_W'(32'sh7FFF_FFFF);
	localparam logic signed [TOT_W-1:0] O_MIN = TOT_W'(32'sh8000_0000);

	logic [CFG_W-1:0] min_q, max_q, stiff_q, damp_q, brkf_q;
	logic             brkable_q;

	logic signed [D_W-1:0]   d_q [3];
	logic signed [D_W-1:0]   dv_q [3];
	logic signed [DIR_W-1:0] dir_q [3];
	logic signed [TOT_W-1:0] f_q [3];
	logic [SUM_W-1:0]        sum_q;
	logic [LEN_W-1:0]        len_q;
	logic signed [DOT_W-1:0] dot_q;
	logic signed [TOT_W-1:0] spring_q, total_q;
	logic [FSUM_W-1:0]       fsum_q;
	op_t                     op_q;
	logic [1:0]              lane_q;

	logic [D_W-1:0]          d_mag [3];
	logic [D_W-1:0]          dv_mag [3];
	logic [DIR_W-2:0]        dir_mag [3];
	logic [TOT_W-2:0]        f_mag [3];
	logic [TOT_W-2:0]        total_mag;
	logic                    over_max, under_min;
	logic [CFG_W-1:0]        bound;
	logic signed [DISP_W-1:0] disp_w;
	logic [DISP_W-1:0]       disp_mag;
	logic [DOT_W-1:0]        dot_abs;
	logic [DOT_W-Q_FRAC-1:0] dot_t;

	logic [MUL_W-1:0]        mul_a, mul_b;
	logic                    mul_start, mul_done, root_done, div_done;
	logic [PROD_W-1:0]       prod;
	logic [LEN_W-1:0]        root;
	logic [DIR_W-2:0]        quo;

	logic [TOT_W-2:0]        msat;
	logic signed [TOT_W-1:0] damp_w;
	logic signed [TOT_W:0]   tsum;
	logic [TOT_W-2:0]        fm;

	function automatic logic signed [FIELD_W-1:0] sat32(input logic signed [TOT_W-1:0] v);
		if (v > O_MAX)
			return O_MAX[FIELD_W-1:0];
		if (v < O_MIN)
			return O_MIN[FIELD_W-1:0];
		return v[FIELD_W-1:0];
	endfunction

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_mag[i]   = d_q[i][D_W-1] ? D_W'(-d_q[i]) : D_W'(d_q[i]);
			dv_mag[i]  = dv_q[i][D_W-1] ? D_W'(-dv_q[i]) : D_W'(dv_q[i]);
			dir_mag[i] = dir_q[i][DIR_W-1] ? (DIR_W-1)'(-dir_q[i]) : (DIR_W-1)'(dir_q[i]);
			f_mag[i]   = f_q[i][TOT_W-1] ? (TOT_W-1)'(-f_q[i]) : (TOT_W-1)'(f_q[i]);
			force_o[i] = cmd.show ? sat32(f_q[i]) : '0;
		end
		total_mag = total_q[TOT_W-1] ? (TOT_W-1)'(-total_q) : (TOT_W-1)'(total_q);
	end

	// upper bound wins when the bounds cross
	assign over_max  = len_q > LEN_W'(max_q);
	assign under_min = len_q < LEN_W'(min_q);
	assign bound     = over_max ? max_q : min_q;
	assign disp_w    = signed'(DISP_W'(len_q)) - signed'(DISP_W'(bound));
	assign disp_mag  = disp_w[DISP_W-1] ? DISP_W'(-disp_w) : DISP_W'(disp_w);
	assign dot_abs   = dot_q[DOT_W-1] ? DOT_W'(-dot_q) : DOT_W'(dot_q);
	assign dot_t     = dot_abs[DOT_W-1:Q_FRAC];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SQ: begin
				mul_a = MUL_W'(d_mag[cmd.lane]);
				mul_b = MUL_W'(d_mag[cmd.lane]);
			end
			OP_DOT: begin
				mul_a = MUL_W'(dv_mag[cmd.lane]);
				mul_b = MUL_W'(dir_mag[cmd.lane]);
			end
			OP_SPRING: begin
				mul_a = MUL_W'(stiff_q);
				mul_b = MUL_W'(disp_mag);
			end
			OP_DAMP: begin
				mul_a = MUL_W'(damp_q);
				mul_b = MUL_W'(dot_t);
			end
			OP_FORCE: begin
				mul_a = MUL_W'(total_mag);
				mul_b = MUL_W'(dir_mag[cmd.lane]);
			end
			OP_FSQ: begin
				mul_a = MUL_W'(f_mag[cmd.lane]);
				mul_b = MUL_W'(f_mag[cmd.lane]);
			end
			OP_BRK: begin
				mul_a = MUL_W'(brkf_q);
				mul_b = MUL_W'(brkf_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_start = cmd.start && (cmd.op inside {OP_SQ, OP_DOT, OP_SPRING, OP_DAMP,
		OP_FORCE, OP_FSQ, OP_BRK});

	dcsf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	dcsf_root u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start && (cmd.op == OP_ROOT)),
		.radicand (sum_q),
		.done     (root_done),
		.root     (root)
	);

	dcsf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start && (cmd.op == OP_DIV)),
		.num    (d_mag[cmd.lane]),
		.den    (len_q),
		.done   (div_done),
		.quo    (quo)
	);

	// product post-processing
	assign msat   = sat_mid(prod[PROD_W-1:Q_FRAC]);
	assign damp_w = dot_q[DOT_W-1] ? signed'({1'b0, msat}) : -signed'({1'b0, msat});
	assign tsum   = (TOT_W+1)'(spring_q) + (TOT_W+1)'(damp_w);
	assign fm     = prod[Q_FRAC+TOT_W-2:Q_FRAC];

	assign stat.done        = mul_done | root_done | div_done;
	assign stat.too_close   = len_q < TOO_CLOSE_RAW;
	assign stat.in_range    = !over_max && !under_min;
	assign stat.spring_mode = stiff_q != '0;
	assign stat.breakable   = brkable_q;
	assign stat.brk         = fsum_q > FSUM_W'(prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q     <= '0;
			max_q     <= '1;
			stiff_q   <= '0;
			damp_q    <= '0;
			brkable_q <= 1'b0;
			brkf_q    <= '1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MIN_DIST:  min_q     <= cfg_wdata;
				REG_MAX_DIST:  max_q     <= cfg_wdata;
				REG_STIFFNESS: stiff_q   <= cfg_wdata;
				REG_DAMPING:   damp_q    <= cfg_wdata;
				REG_BREAKABLE: brkable_q <= cfg_wdata[0];
				REG_BREAK_F:   brkf_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q   <= cmd.op;
			lane_q <= cmd.lane;
		end
		if (cmd.load) begin
			for (int i = 0; i < 3; i++) begin
				d_q[i]  <= D_W'(pos_b[i]) - D_W'(pos_a[i]);
				dv_q[i] <= D_W'(vel_b[i]) - D_W'(vel_a[i]);
			end
			sum_q  <= '0;
			dot_q  <= '0;
			fsum_q <= '0;
		end
		if (cmd.plain)
			total_q <= TOT_W'(-disp_w);
		if (root_done)
			len_q <= root;
		if (div_done)
			dir_q[lane_q] <= d_q[lane_q][D_W-1] ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
		if (mul_done) begin
			case (op_q)
				OP_SQ:  sum_q <= sum_q + prod[SUM_W-1:0];
				OP_DOT: begin
					if (dv_q[lane_q][D_W-1] ^ dir_q[lane_q][DIR_W-1])
						dot_q <= dot_q - signed'(DOT_W'(prod[DOT_W-3:0]));
					else
						dot_q <= dot_q + signed'(DOT_W'(prod[DOT_W-3:0]));
				end
				OP_SPRING: spring_q <= disp_w[DISP_W-1] ? signed'({1'b0, msat})
					: -signed'({1'b0, msat});
				OP_DAMP: begin
					if (tsum > MID_POS)
						total_q <= MID_POS[TOT_W-1:0];
					else if (tsum < MID_NEG)
						total_q <= MID_NEG[TOT_W-1:0];
					else
						total_q <= tsum[TOT_W-1:0];
				end
				OP_FORCE: f_q[lane_q] <= (total_q[TOT_W-1] ^ dir_q[lane_q][DIR_W-1])
					? -signed'({1'b0, fm}) : signed'({1'b0, fm});
				OP_FSQ: fsum_q <= fsum_q + prod[FSUM_W-1:0];
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- sv/dcsf_ctrl.sv -----
// controller: sequences the datapath operations, holds the broken latch and the result handshake
`default_nettype none
module dcsf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output dcsf_pkg::outcome_t   outcome,
	output dcsf_pkg::cmd_t       cmd,
	input  dcsf_pkg::stat_t      stat
);
	import dcsf_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_SQ     = 12'b0000_0000_0010,
		S_ROOT   = 12'b0000_0000_0100,
		S_CHK    = 12'b0000_0000_1000,
		S_DIV    = 12'b0000_0001_0000,
		S_DOT    = 12'b0000_0010_0000,
		S_SPRING = 12'b0000_0100_0000,
		S_DAMP   = 12'b0000_1000_0000,
		S_FORCE  = 12'b0001_0000_0000,
		S_FSQ    = 12'b0010_0000_0000,
		S_BRK    = 12'b0100_0000_0000,
		S_OUT    = 12'b1000_0000_0000
	} state_t;

	state_t     state_q;
	logic [1:0] lane_q;
	logic       wait_q, broken_q;
	outcome_t   outcome_q;
	logic       acc_in, step_done, multi, last;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign outcome   = outcome_q;
	assign acc_in    = in_valid && in_ready;
	assign step_done = wait_q && stat.done;
	assign multi     = (state_q == S_SQ) || (state_q == S_DIV) || (state_q == S_DOT)
		|| (state_q == S_FORCE) || (state_q == S_FSQ);
	assign last      = !multi || (lane_q == LAST_LANE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_SQ:     cmd.op = OP_SQ;
			S_ROOT:   cmd.op = OP_ROOT;
			S_DIV:    cmd.op = OP_DIV;
			S_DOT:    cmd.op = OP_DOT;
			S_SPRING: cmd.op = OP_SPRING;
			S_DAMP:   cmd.op = OP_DAMP;
			S_FORCE:  cmd.op = OP_FORCE;
			S_FSQ:    cmd.op = OP_FSQ;
			S_BRK:    cmd.op = OP_BRK;
			default:  cmd.op = OP_NONE;
		endcase
		cmd.load  = acc_in;
		cmd.start = (cmd.op != OP_NONE) && !wait_q;
		cmd.lane  = lane_q;
		// no spring: total is the negated displacement
		cmd.plain = (state_q == S_DIV) && step_done && last && !stat.spring_mode;
		cmd.show  = outcome_q == OUT_APPLIED;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			lane_q    <= '0;
			wait_q    <= 1'b0;
			broken_q  <= 1'b0;
			outcome_q <= OUT_WITHIN;
		end else begin
			if (cmd.start)
				wait_q <= 1'b1;
			if (step_done) begin
				wait_q <= 1'b0;
				lane_q <= last ? 2'd0 : lane_q + 2'd1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						if (broken_q) begin
							outcome_q <= OUT_BROKEN;
							state_q   <= S_OUT;
						end else begin
							state_q <= S_SQ;
						end
					end
				end
				S_SQ: if (step_done && last) state_q <= S_ROOT;
				S_ROOT: if (step_done) state_q <= S_CHK;
				S_CHK: begin
					if (stat.too_close) begin
						outcome_q <= OUT_TOO_CLOSE;
						state_q   <= S_OUT;
					end else if (stat.in_range) begin
						outcome_q <= OUT_WITHIN;
						state_q   <= S_OUT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: if (step_done && last) state_q <= stat.spring_mode ? S_DOT : S_FORCE;
				S_DOT: if (step_done && last) state_q <= S_SPRING;
				S_SPRING: if (step_done) state_q <= S_DAMP;
				S_DAMP: if (step_done) state_q <= S_FORCE;
				S_FORCE: begin
					if (step_done && last) begin
						if (stat.breakable) begin
							state_q <= S_FSQ;
						end else begin
							outcome_q <= OUT_APPLIED;
							state_q   <= S_OUT;
						end
					end
				end
				S_FSQ: if (step_done && last) state_q <= S_BRK;
				S_BRK: begin
					if (step_done) begin
						if (stat.brk) begin
							broken_q  <= 1'b1;
							outcome_q <= OUT_BROKE;
						end else begin
							outcome_q <= OUT_APPLIED;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_broken_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		broken_q |=> broken_q)
		else $error("broken latch cleared without reset");

	a_broken_short: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && broken_q) |=> (state_q == S_OUT) && (outcome_q == OUT_BROKEN))
		else $error("broken constraint did not answer at once");

	a_start_waits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> wait_q)
		else $error("operation started without waiting for it");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");
endmodule
`default_nettype wire
